// File: sv/sequence_reorder_reassembly_assert.svh
// Assertion macros shared by the reorder buffer modules.
`ifndef SEQUENCE_REORDER_REASSEMBLY_ASSERT_SVH
`define SEQUENCE_REORDER_REASSEMBLY_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srr assertion failed");

// antecedent implies consequent in the next cycle
`define SRR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srr assertion failed");

`endif

// File: sv/srr_pkg.sv
// Package: window size, payload types and index helper of the reorder buffer.
`default_nettype none
package srr_pkg;
  localparam int WINDOW = 64;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int REL_W  = $clog2(WINDOW + 1);
  localparam int CMP_W  = ((REL_W > 8) ? REL_W : 8) + 1;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  frag_count;
    logic [15:0] opcode;
    logic [15:0] payload_tag;
    logic [15:0] payload_length;
  } item_t;

  typedef struct packed {
    logic [15:0] seq_out;
    logic [15:0] opcode_out;
    logic [15:0] tag_out;
    logic [15:0] length_out;
    logic        message_end;
    logic [21:0] message_length;
    logic [15:0] next_expected;
    logic        last_in_run;
  } result_t;

  typedef struct packed {
    item_t            item;
    logic [IDX_W-1:0] idx;
  } ins_t;

  typedef struct packed {
    logic [15:0]       exp_seq;
    logic [IDX_W-1:0]  head;
    logic [WINDOW-1:0] valid;
  } status_t;

  // physical slot of relative offset rel from head (rel at most the window)
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] head,
                                                input logic [REL_W-1:0] rel);
    logic [REL_W+1:0] s;
    s = {{(REL_W+2-IDX_W){1'b0}}, head} + {2'b00, rel};
    if (s >= (REL_W+2)'(WINDOW)) s = s - (REL_W+2)'(WINDOW);
    return s[IDX_W-1:0];
  endfunction
endpackage
`default_nettype wire

// File: sv/srr_front.sv
// Front end: registers a request and classifies it as drop or slot insert.
`default_nettype none
module srr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire srr_pkg::item_t  item,
  input  wire srr_pkg::status_t status,
  output logic                 pending,
  output logic                 push,
  output srr_pkg::ins_t        push_data
);
  srr_pkg::item_t hold;
  logic [15:0] off;
  logic in_range;
  logic [srr_pkg::IDX_W-1:0] phys;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= accept;
    end
    if (accept) hold <= item;
  end

  always_comb begin
    off = hold.seq - status.exp_seq;
    in_range = !off[15] && (off < 16'(srr_pkg::WINDOW));
    phys = srr_pkg::wrap_add(status.head, off[srr_pkg::REL_W-1:0]);
    push = pending && in_range && !status.valid[phys];
    push_data.item = hold;
    push_data.idx = phys;
  end
endmodule
`default_nettype wire

// File: sv/srr_fifo.sv
// Two-entry queue of slot inserts between front and back.
`default_nettype none
module srr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire srr_pkg::ins_t push_data,
  input  wire logic          pop,
  output srr_pkg::ins_t      head_data,
  output logic               empty
);
  `include "sequence_reorder_reassembly_assert.svh"

  srr_pkg::ins_t ent [2];
  logic wp, rp;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) ent[wp] <= push_data;
  end

  assign head_data = ent[rp];
  assign empty = (cnt == 2'd0);

  `SRR_ASSERT_NOW(a_no_overflow, push && !pop, cnt != 2'd2)
  `SRR_ASSERT_NOW(a_no_underflow, pop, cnt != 2'd0)
  `SRR_ASSERT_NXT(a_count_up, push && !pop && cnt == 2'd0, !empty)
endmodule
`default_nettype wire

// File: sv/srr_back.sv
// Back end: slot store, insert, in-order release scan and group reassembly.
`default_nettype none
module srr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire srr_pkg::ins_t  head_data,
  output logic                pop,
  output logic                active,
  output srr_pkg::status_t    status,
  output logic                strobe,
  output srr_pkg::result_t    result
);
  `include "sequence_reorder_reassembly_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_HCHK = 3'd2;
  localparam logic [2:0] S_P1   = 3'd3;
  localparam logic [2:0] S_P1D  = 3'd4;
  localparam logic [2:0] S_P2RD = 3'd5;
  localparam logic [2:0] S_P2D  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam int RW = srr_pkg::REL_W;
  localparam int CW = srr_pkg::CMP_W;

  srr_pkg::item_t mem [srr_pkg::WINDOW];
  srr_pkg::item_t rdata;

  logic [2:0] state;
  logic [15:0] exp_seq;
  logic [srr_pkg::IDX_W-1:0] head, wr_idx;
  logic [srr_pkg::WINDOW-1:0] valid;
  logic [RW-1:0] i, j, gend;
  logic [21:0] total;
  logic [15:0] gop;
  srr_pkg::result_t pend;
  srr_pkg::result_t pend_last;
  logic pv;

  logic [srr_pkg::IDX_W-1:0] phys_i, phys_j, rd_addr;
  logic grp_end;
  logic too_big;

  function automatic srr_pkg::result_t mk(input srr_pkg::item_t e, input logic [15:0] op,
                                          input logic fin, input logic [21:0] mlen);
    srr_pkg::result_t r;
    r.seq_out = e.seq;
    r.opcode_out = op;
    r.tag_out = e.payload_tag;
    r.length_out = e.payload_length;
    r.message_end = fin;
    r.message_length = fin ? mlen : 22'd0;
    r.next_expected = e.seq + 16'd1;
    r.last_in_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    phys_i = srr_pkg::wrap_add(head, i);
    phys_j = srr_pkg::wrap_add(head, j);
    rd_addr = (state == S_HEAD) ? phys_i : phys_j;
    grp_end = ((j + RW'(1)) == gend);
    too_big = {{(CW-8){1'b0}}, rdata.frag_count} >
              (CW'(srr_pkg::WINDOW) - {{(CW-RW){1'b0}}, i});
    pop = (state == S_IDLE) && !empty;
    active = (state != S_IDLE);
    status.exp_seq = exp_seq;
    status.head = head;
    status.valid = valid;
    pend_last = pend;
    pend_last.last_in_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (pop) mem[head_data.idx] <= head_data.item;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      exp_seq <= 16'd0;
      head <= '0;
      valid <= '0;
      pv <= 1'b0;
      strobe <= 1'b0;
      i <= '0;
      j <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            valid[head_data.idx] <= 1'b1;
            wr_idx <= head_data.idx;
            i <= '0;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (i == RW'(srr_pkg::WINDOW) || !valid[phys_i]) state <= S_FIN;
          else state <= S_HCHK;
        end
        S_HCHK: begin
          if (rdata.frag_count == 8'd0) begin
            if (pv) begin
              result <= pend;
              strobe <= 1'b1;
            end
            pend <= mk(rdata, rdata.opcode, 1'b1, {6'd0, rdata.payload_length});
            pv <= 1'b1;
            valid[phys_i] <= 1'b0;
            i <= i + RW'(1);
            state <= S_HEAD;
          end else if (too_big) begin
            state <= S_FIN;
          end else begin
            total <= {6'd0, rdata.payload_length};
            gop <= rdata.opcode;
            gend <= i + RW'(rdata.frag_count);
            j <= i + RW'(1);
            state <= S_P1;
          end
        end
        S_P1: begin
          if (j == gend) begin
            j <= i;
            state <= S_P2RD;
          end else if (!valid[phys_j]) begin
            state <= S_FIN;
          end else begin
            state <= S_P1D;
          end
        end
        S_P1D: begin
          total <= total + {6'd0, rdata.payload_length};
          j <= j + RW'(1);
          state <= S_P1;
        end
        S_P2RD: begin
          state <= S_P2D;
        end
        S_P2D: begin
          if (pv) begin
            result <= pend;
            strobe <= 1'b1;
          end
          pend <= mk(rdata, gop, grp_end, total);
          pv <= 1'b1;
          valid[phys_j] <= 1'b0;
          j <= j + RW'(1);
          if (grp_end) begin
            i <= gend;
            state <= S_HEAD;
          end else begin
            state <= S_P2RD;
          end
        end
        S_FIN: begin
          if (pv) begin
            result <= pend_last;
            strobe <= 1'b1;
          end
          pv <= 1'b0;
          head <= srr_pkg::wrap_add(head, i);
          exp_seq <= exp_seq + 16'(i);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRR_ASSERT_NXT(a_insert_marks_valid, pop, valid[wr_idx])
  `SRR_ASSERT_NOW(a_len_only_at_end, strobe && !result.message_end,
                  result.message_length == 22'd0)
  `SRR_ASSERT_NXT(a_last_ends_run, strobe && result.last_in_run, !strobe)
endmodule
`default_nettype wire

// File: sv/sequence_reorder_reassembly.sv
// Top level of the receive-side reorder buffer with fragment reassembly.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------
//  request  | start & !busy         | item   (srr_pkg::item_t)
//  result   | strobe, one cycle     | result (srr_pkg::result_t)
//
// A dropped request ends in the front end; an insert goes on to the back end, which releases
// whole packets and fragment groups in order, reading the slot store one slot at a time
// through its single read port; a group whose fragments are missing or that does not fit
// in the window stops release.
// Reset clears expected sequence, head pointer and slot valid bits.
// busy falls in the cycle that shows the last result of a request; results cannot stall.
`default_nettype none
module sequence_reorder_reassembly (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire srr_pkg::item_t   item,
  output logic                  busy,
  output logic                  strobe,
  output srr_pkg::result_t      result
);
  logic accept, pending, push, pop, empty, active;
  srr_pkg::ins_t push_data, head_data;
  srr_pkg::status_t status;

  assign accept = start && !busy;
  assign busy = pending || !empty || active;

  srr_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .item(item), .status(status),
    .pending(pending), .push(push), .push_data(push_data)
  );

  srr_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .head_data(head_data), .empty(empty)
  );

  srr_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .head_data(head_data), .pop(pop),
    .active(active), .status(status), .strobe(strobe), .result(result)
  );
endmodule
`default_nettype wire
